/* sv/heightmap_normal_central_difference_defines.svh */
// Assertion macros used by the checker file of the heightmap normal block.
// Each macro expands to one labelled concurrent assertion clocked on the rising edge.
`ifndef HEIGHTMAP_NORMAL_CENTRAL_DIFFERENCE_DEFINES_SVH
`define HEIGHTMAP_NORMAL_CENTRAL_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HNCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HNCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/hncd_pkg.sv */
// Shared constants, register codes and inter-module structs of the heightmap normal block.
// No dependencies; every other file of the block but the defines header imports this package.
package hncd_pkg;

   localparam int MaxRowWidth  = 256;
   localparam int MinRowWidth  = 4;
   localparam int ColBits      = $clog2(MaxRowWidth);
   localparam int RowWidthBits = ColBits + 1;
   localparam int ScaleBits    = 16;
   localparam int SampleBits   = 16;
   localparam int CoordBits    = 8;
   localparam int NormBits     = 16;

   localparam int CsrIndexBits = 1;
   localparam int CsrDataBits  = 16;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_ROW_WIDTH    = 1'b0,
      CSR_HEIGHT_SCALE = 1'b1
   } csr_index_type;

   localparam logic [RowWidthBits-1:0] RowWidthReset = RowWidthBits'(67);
   localparam logic [ScaleBits-1:0]    ScaleReset    = ScaleBits'(256);

   // Arithmetic widths: scaled differences, shifted magnitudes, squares and root.
   localparam int ProdBits    = 2 * SampleBits;
   localparam int MagBits     = 30;
   localparam int SqBits      = 2 * MagBits;
   localparam int SumBits     = SqBits + 2;
   localparam int RootBits    = 32;
   localparam int IsqBits     = 2 * RootBits;
   localparam int FracBits    = 15;
   localparam int QuotBits    = FracBits + 1;
   localparam int QuotCntBits = $clog2(QuotBits);
   localparam int DivNumBits  = MagBits + FracBits + 1;
   localparam int DivDenBits  = RootBits + FracBits;
   localparam int Lanes       = 3;

   // Vertical term of the unnormalised normal, two full sample ranges.
   localparam logic [ProdBits-1:0] YTerm  = ProdBits'(2 * 65535);
   localparam logic [NormBits-1:0] Q15Max = NormBits'(32767);

   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [ColBits-1:0]    col;
      logic [SampleBits-1:0] sample;
   } ls_cmd_type;

   typedef struct packed {
      logic [SampleBits-1:0] up;
      logic [SampleBits-1:0] centre;
      logic [SampleBits-1:0] right;
   } ls_data_type;

   typedef struct packed {
      logic                           start;
      logic [RootBits-1:0]            root;
      logic [Lanes-1:0][MagBits-1:0]  mag;
      logic [Lanes-1:0]               neg;
   } div_req_type;

   typedef struct packed {
      logic                           done;
      logic [Lanes-1:0][NormBits-1:0] norm;
   } div_rsp_type;

endpackage

/* sv/hncd_req_if.sv */
// Sample channel into the heightmap normal block: valid, ready, one height sample and a frame start flag.
// Depends on hncd_pkg for the field widths.
interface hncd_req_if;
   import hncd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SampleBits-1:0] height_sample;
   logic                  frame_start;

   modport source (output valid, output height_sample, output frame_start, input ready);
   modport sink   (input valid, input height_sample, input frame_start, output ready);
endinterface

/* sv/hncd_rsp_if.sv */
// Normal channel out of the heightmap normal block: valid, ready and one vertex normal.
// Depends on hncd_pkg for the field widths.
interface hncd_rsp_if;
   import hncd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CoordBits-1:0]       grid_x;
   logic [CoordBits-1:0]       grid_z;
   logic signed [NormBits-1:0] normal_x;
   logic signed [NormBits-1:0] normal_y;
   logic signed [NormBits-1:0] normal_z;
   logic                       last_normal;

   modport source (output valid, output grid_x, output grid_z, output normal_x,
                   output normal_y, output normal_z, output last_normal, input ready);
   modport sink   (input valid, input grid_x, input grid_z, input normal_x,
                   input normal_y, input normal_z, input last_normal, output ready);
endinterface

/* sv/hncd_line_store.sv */
// Two line stores holding the previous two heightmap rows, with registered reads.
// Depends on hncd_pkg for the command and data structs.
module hncd_line_store (
   input  logic                 clock,
   input  hncd_pkg::ls_cmd_type cmd,
   output hncd_pkg::ls_data_type data
);
   import hncd_pkg::*;

   logic [SampleBits-1:0] older_mem [MaxRowWidth];
   logic [SampleBits-1:0] newer_mem [MaxRowWidth];
   logic [SampleBits-1:0] up_ff;
   logic [SampleBits-1:0] centre_ff;
   logic [SampleBits-1:0] right_ff;
   logic [ColBits-1:0]    next_col;

   assign next_col = cmd.col + ColBits'(1);

   // The write-back comes in the cycle after the read of the same column, so the
   // older row takes the newer row's entry straight from the read register.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         up_ff     <= older_mem[cmd.col];
         centre_ff <= newer_mem[cmd.col];
         right_ff  <= newer_mem[next_col];
      end
      if (cmd.wr_en) begin
         older_mem[cmd.col] <= centre_ff;
         newer_mem[cmd.col] <= cmd.sample;
      end
   end

   assign data.up     = up_ff;
   assign data.centre = centre_ff;
   assign data.right  = right_ff;

endmodule

/* sv/hncd_isqrt.sv */
// Integer square root giving a 32-bit root, one result bit per cycle.
// Depends on hncd_pkg for the operand widths.
module hncd_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hncd_pkg::SumBits-1:0]  radicand,
   output logic                          done,
   output logic [hncd_pkg::RootBits-1:0] root
);
   import hncd_pkg::*;

   localparam logic [IsqBits-1:0] FirstBit = IsqBits'(1) << (IsqBits - 2);

   logic [IsqBits-1:0] rem_ff;
   logic [IsqBits-1:0] res_ff;
   logic [IsqBits-1:0] bit_ff;
   logic               busy_ff;
   logic               busy_in;
   logic               done_ff;
   logic               done_in;
   logic [IsqBits-1:0] trial;
   logic               take;

   assign trial = res_ff + bit_ff;
   assign take  = rem_ff >= trial;

   always_comb begin
      done_in = busy_ff && bit_ff[0];
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && bit_ff[0]) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= IsqBits'(radicand);
         res_ff <= '0;
         bit_ff <= FirstBit;
      end else if (busy_ff) begin
         if (take) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[RootBits-1:0];

endmodule

/* sv/hncd_divider.sv */
// Three-lane restoring divider giving rounded, saturated, signed Q1.15 components.
// Depends on hncd_pkg for the request and response structs.
module hncd_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  hncd_pkg::div_req_type req,
   output hncd_pkg::div_rsp_type rsp
);
   import hncd_pkg::*;

   logic [DivNumBits-1:0]  num_ff [Lanes];
   logic [QuotBits-1:0]    quot_ff [Lanes];
   logic [Lanes-1:0]       neg_ff;
   logic [DivDenBits-1:0]  den_ff;
   logic [QuotCntBits-1:0] cnt_ff;
   logic [QuotCntBits-1:0] cnt_in;
   logic                   busy_ff;
   logic                   busy_in;
   logic                   done_ff;
   logic                   done_in;
   logic [Lanes-1:0]       ge;
   logic [NormBits-1:0]    mag_q [Lanes];

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         ge[k] = DivDenBits'(num_ff[k]) >= den_ff;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = busy_ff && (cnt_ff == '0);
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = QuotCntBits'(QuotBits - 1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - QuotCntBits'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // The numerator carries half the divisor so that the truncating quotient rounds.
   always_ff @(posedge clock) begin
      if (req.start) begin
         for (int k = 0; k < Lanes; k++) begin
            num_ff[k]  <= DivNumBits'({req.mag[k], FracBits'(0)})
                          + DivNumBits'(req.root >> 1);
            quot_ff[k] <= '0;
         end
         neg_ff <= req.neg;
         den_ff <= DivDenBits'(req.root) << FracBits;
      end else if (busy_ff) begin
         for (int k = 0; k < Lanes; k++) begin
            if (ge[k]) begin
               num_ff[k] <= num_ff[k] - DivNumBits'(den_ff);
            end
            quot_ff[k] <= {quot_ff[k][QuotBits-2:0], ge[k]};
         end
         den_ff <= den_ff >> 1;
      end
   end

   // A magnitude never exceeds the root, so the quotient is at most one past Q15Max.
   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         mag_q[k] = quot_ff[k][QuotBits-1] ? Q15Max : {1'b0, quot_ff[k][QuotBits-2:0]};
         rsp.norm[k] = neg_ff[k] ? (NormBits'(0) - mag_q[k]) : mag_q[k];
      end
   end

   assign rsp.done = done_ff;

endmodule

/* sv/heightmap_normal_central_difference.sv */
// Channel   Dir  Payload                                           Transaction
// req_chan  in   height_sample[15:0], frame_start                  valid & ready
// rsp_chan  out  grid_x, grid_z, normal_x/y/z (Q1.15), last_normal  valid & ready
// csr_*     in   csr_index selects row_width or height_scale       csr_wr_en
//
// A border sample passes through acceptance and the line store read-modify-write.
// An interior sample goes on through scaling, shifting, squaring, the bit-serial square root
// (32 steps) and the 16-step three-lane divider. Synchronous reset clears the counters, the
// sequencer, the root and divider control flags and the output valid and sets the CSRs to
// defaults; other registers and the line stores are not cleared. A stalled result waits in
// the output register while the next sample is taken; only a second finished normal waits for it.
module heightmap_normal_central_difference (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [hncd_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [hncd_pkg::CsrDataBits-1:0]  csr_wr_data,
   hncd_req_if.sink                          req_chan,
   hncd_rsp_if.source                        rsp_chan
);
   import hncd_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_READ   = 8'b0000_0010,
      ST_MUL    = 8'b0000_0100,
      ST_SHIFT  = 8'b0000_1000,
      ST_SQUARE = 8'b0001_0000,
      ST_ROOT   = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   localparam logic [1:0] SquareLast = 2'd3;

   state_type               state_ff;
   state_type               state_in;
   logic [RowWidthBits-1:0] row_width_ff;
   logic [ScaleBits-1:0]    height_scale_ff;
   logic [ColBits-1:0]      col_count_ff;
   logic [ColBits-1:0]      col_count_in;
   logic [ColBits-1:0]      row_count_ff;
   logic [ColBits-1:0]      row_count_in;
   logic [1:0]              step_ff;
   logic [1:0]              step_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic [ColBits-1:0]      col_ff;
   logic [SampleBits-1:0]   sample_ff;
   logic [SampleBits-1:0]   left_ff;
   logic                    interior_ff;
   logic                    last_ff;
   logic [CoordBits-1:0]    grid_x_ff;
   logic [CoordBits-1:0]    grid_z_ff;
   logic [SampleBits-1:0]   mag_dx_ff;
   logic [SampleBits-1:0]   mag_dz_ff;
   logic                    neg_x_ff;
   logic                    neg_z_ff;
   logic [ProdBits-1:0]     prod_x_ff;
   logic [ProdBits-1:0]     prod_z_ff;
   logic [MagBits-1:0]      mag_ff [Lanes];
   logic [SqBits-1:0]       sq_ff;
   logic [SumBits-1:0]      sum_ff;

   logic [CoordBits-1:0]       out_grid_x_ff;
   logic [CoordBits-1:0]       out_grid_z_ff;
   logic signed [NormBits-1:0] out_normal_x_ff;
   logic signed [NormBits-1:0] out_normal_y_ff;
   logic signed [NormBits-1:0] out_normal_z_ff;
   logic                       out_last_ff;

   logic [RowWidthBits-1:0] width;
   logic [ColBits-1:0]      cur_col;
   logic [ColBits-1:0]      cur_row;
   logic [RowWidthBits-1:0] col_ext;
   logic [RowWidthBits-1:0] row_ext;
   logic                    is_interior;
   logic                    is_last;
   logic                    accept;
   logic                    out_free;
   logic                    out_load;
   logic [SampleBits:0]     dx;
   logic [SampleBits:0]     dz;
   logic [ProdBits-1:0]     prod_max;
   logic [1:0]              shamt;
   logic [MagBits-1:0]      sq_op;
   logic                    root_done;
   logic [RootBits-1:0]     root;
   logic [RootBits-1:0]     root_div;

   ls_cmd_type  ls_cmd;
   ls_data_type ls_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= RowWidthReset;
         height_scale_ff <= ScaleReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_WIDTH:    row_width_ff    <= csr_wr_data[RowWidthBits-1:0];
            CSR_HEIGHT_SCALE: height_scale_ff <= csr_wr_data[ScaleBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (row_width_ff < RowWidthBits'(MinRowWidth)) begin
         width = RowWidthBits'(MinRowWidth);
      end else if (row_width_ff > RowWidthBits'(MaxRowWidth)) begin
         width = RowWidthBits'(MaxRowWidth);
      end else begin
         width = row_width_ff;
      end
   end

   assign cur_col = req_chan.frame_start ? '0 : col_count_ff;
   assign cur_row = req_chan.frame_start ? '0 : row_count_ff;
   assign col_ext = {1'b0, cur_col};
   assign row_ext = {1'b0, cur_row};

   // The normal of the vertex above is complete once the sample below it arrives.
   assign is_interior = (cur_row >= ColBits'(2)) && (row_ext <= width - RowWidthBits'(1))
                        && (cur_col != '0) && (col_ext <= width - RowWidthBits'(2));
   assign is_last     = (row_ext == width - RowWidthBits'(1))
                        && (col_ext == width - RowWidthBits'(2));

   assign accept   = (state_ff == ST_IDLE) && req_chan.valid;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign out_load = (state_ff == ST_OUT) && out_free;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_ext + RowWidthBits'(1) >= width) begin
            col_count_in = '0;
            row_count_in = (row_ext + RowWidthBits'(1) >= width) ? '0
                                                               : cur_row + ColBits'(1);
         end else begin
            col_count_in = cur_col + ColBits'(1);
            row_count_in = cur_row;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = interior_ff ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            state_in = ST_SQUARE;
            step_in  = '0;
         end
         ST_SQUARE: begin
            step_in = step_ff + 2'd1;
            if (step_ff == SquareLast) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_count_ff <= '0;
         row_count_ff <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------- line store
   assign ls_cmd.rd_en  = accept;
   assign ls_cmd.wr_en  = (state_ff == ST_READ);
   assign ls_cmd.col    = accept ? cur_col : col_ff;
   assign ls_cmd.sample = sample_ff;

   hncd_line_store u_line_store (
      .clock (clock),
      .cmd   (ls_cmd),
      .data  (ls_data)
   );

   // ---------------------------------------------------------------- datapath
   // The left neighbour is the newer-row entry read for the previous column,
   // which is always the transaction just before any interior one.
   assign dx = {1'b0, ls_data.right} - {1'b0, left_ff};
   assign dz = {1'b0, sample_ff} - {1'b0, ls_data.up};

   always_comb begin
      prod_max = YTerm;
      if (prod_x_ff > prod_max) begin
         prod_max = prod_x_ff;
      end
      if (prod_z_ff > prod_max) begin
         prod_max = prod_z_ff;
      end
      if (prod_max[ProdBits-1]) begin
         shamt = 2'd2;
      end else if (prod_max[ProdBits-2]) begin
         shamt = 2'd1;
      end else begin
         shamt = 2'd0;
      end
   end

   always_comb begin
      case (step_ff)
         2'd0:    sq_op = mag_ff[0];
         2'd1:    sq_op = mag_ff[1];
         2'd2:    sq_op = mag_ff[2];
         default: sq_op = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff      <= cur_col;
         sample_ff   <= req_chan.height_sample;
         interior_ff <= is_interior;
         last_ff     <= is_last;
         grid_x_ff   <= cur_col - ColBits'(1);
         grid_z_ff   <= cur_row - ColBits'(2);
      end
      if (state_ff == ST_READ) begin
         left_ff   <= ls_data.centre;
         neg_x_ff  <= dx[SampleBits];
         neg_z_ff  <= dz[SampleBits];
         mag_dx_ff <= dx[SampleBits] ? SampleBits'(-dx) : dx[SampleBits-1:0];
         mag_dz_ff <= dz[SampleBits] ? SampleBits'(-dz) : dz[SampleBits-1:0];
      end
      if (state_ff == ST_MUL) begin
         prod_x_ff <= ProdBits'(mag_dx_ff) * ProdBits'(height_scale_ff);
         prod_z_ff <= ProdBits'(mag_dz_ff) * ProdBits'(height_scale_ff);
      end
      if (state_ff == ST_SHIFT) begin
         mag_ff[0] <= MagBits'(prod_x_ff >> shamt);
         mag_ff[1] <= MagBits'(YTerm >> shamt);
         mag_ff[2] <= MagBits'(prod_z_ff >> shamt);
      end
      if (state_ff == ST_SQUARE) begin
         sq_ff  <= SqBits'(sq_op) * SqBits'(sq_op);
         sum_ff <= (step_ff == '0) ? '0 : sum_ff + SumBits'(sq_ff);
      end
   end

   hncd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_SQUARE) && (step_ff == SquareLast)),
      .radicand (sum_ff + SumBits'(sq_ff)),
      .done     (root_done),
      .root     (root)
   );

   assign root_div = (root == '0) ? RootBits'(1) : root;

   assign div_req.start  = (state_ff == ST_ROOT) && root_done;
   assign div_req.root   = root_div;
   assign div_req.mag[0] = mag_ff[0];
   assign div_req.mag[1] = mag_ff[1];
   assign div_req.mag[2] = mag_ff[2];
   assign div_req.neg    = {neg_z_ff, 1'b0, neg_x_ff};

   hncd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ------------------------------------------------------------ output stage
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_grid_x_ff   <= grid_x_ff;
         out_grid_z_ff   <= grid_z_ff;
         out_normal_x_ff <= signed'(div_rsp.norm[0]);
         out_normal_y_ff <= signed'(div_rsp.norm[1]);
         out_normal_z_ff <= signed'(div_rsp.norm[2]);
         out_last_ff     <= last_ff;
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.grid_x      = out_grid_x_ff;
   assign rsp_chan.grid_z      = out_grid_z_ff;
   assign rsp_chan.normal_x    = out_normal_x_ff;
   assign rsp_chan.normal_y    = out_normal_y_ff;
   assign rsp_chan.normal_z    = out_normal_z_ff;
   assign rsp_chan.last_normal = out_last_ff;

endmodule

/* sv/hncd_checker.sv */
// Port-level checks for the heightmap normal block, bound to its top level.
// Depends on hncd_pkg and the assertion macros in the defines header.
`include "heightmap_normal_central_difference_defines.svh"

module hncd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [hncd_pkg::CoordBits-1:0] rsp_grid_x,
   input logic [hncd_pkg::CoordBits-1:0] rsp_grid_z,
   input logic [hncd_pkg::NormBits-1:0]  rsp_normal_y
);
   import hncd_pkg::*;

   localparam logic [CoordBits-1:0] MaxGrid = CoordBits'(MaxRowWidth - 3);

   // A stalled result must stay offered until it is taken.
   `HNCD_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

   // The sequencer leaves the idle state as soon as a sample transaction completes.
   `HNCD_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second sample taken while busy")

   // After reset the block is idle and ready for a sample.
   `HNCD_ASSERT_IMP(a_ready_after_reset, clock, reset, $past(reset), req_ready, "not ready after reset")

   // The vertical component points upwards for every vertex.
   `HNCD_ASSERT_IMP(a_normal_y_sign, clock, reset, rsp_valid, !rsp_normal_y[NormBits-1], "normal_y negative")

   // Border samples never produce a vertex, so coordinates stay inside the interior.
   `HNCD_ASSERT_IMP(a_grid_range, clock, reset, rsp_valid, (rsp_grid_x <= MaxGrid) && (rsp_grid_z <= MaxGrid), "grid coordinate out of range")

endmodule

bind heightmap_normal_central_difference hncd_checker u_hncd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_grid_x   (rsp_chan.grid_x),
   .rsp_grid_z   (rsp_chan.grid_z),
   .rsp_normal_y (rsp_chan.normal_y)
);

/* bench/heightmap_normal_central_difference_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for heightmap_normal_central_difference: streams heightmap frames
// through the sample channel and checks every normal against a behavioural predictor or a fixed demo value.
// Depends on hncd_pkg, the hncd_req_if and hncd_rsp_if interfaces and the block itself.
module heightmap_normal_central_difference_test;
   import hncd_pkg::*;

   localparam int SettleCycles = 80;
   localparam int RandomItems  = 500;
   localparam int HoldCycles   = 600;
   localparam int HoldAfter    = 40;
   localparam int DemoRows     = 25;

   typedef struct packed {
      logic [CoordBits-1:0]       grid_x;
      logic [CoordBits-1:0]       grid_z;
      logic signed [NormBits-1:0] normal_x;
      logic signed [NormBits-1:0] normal_y;
      logic signed [NormBits-1:0] normal_z;
      logic                       last_normal;
   } vertex_normal_t;

   typedef struct {
      logic [SampleBits-1:0] height;
      logic                  frame_start;
      bit                    known;
      vertex_normal_t        want;
   } demo_row_t;

   typedef enum int {HEIGHT_NOISE, HEIGHT_SMOOTH, HEIGHT_EXTREME, HEIGHT_LOW} height_mode_t;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_wr_data;

   hncd_req_if req_if ();
   hncd_rsp_if rsp_if ();

   heightmap_normal_central_difference u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   // Predictor state: both line stores, the raster counters and the two registers.
   logic [SampleBits-1:0] older_row [MaxRowWidth] = '{default: '0};
   logic [SampleBits-1:0] newer_row [MaxRowWidth] = '{default: '0};
   int unsigned           pred_col  = 0;
   int unsigned           pred_row  = 0;
   int unsigned           width_reg = RowWidthReset;
   int unsigned           scale_reg = ScaleReset;

   vertex_normal_t        normals_due [$];
   int unsigned           mismatch_count = 0;
   int unsigned           burst_left = 0;
   bit                    gaps_on = 1'b1;
   logic [SampleBits-1:0] last_height = '0;

   // A 4 x 4 frame of extreme heights, then restarts by wrap-around and mid-row.
   demo_row_t demo_rows [DemoRows] = '{
      '{16'd0,     1'b1, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b1, '{8'd0, 8'd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0}},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd1234,  1'b0, 1'b0, '0},
      '{16'd40000, 1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'd32768, 1'b0, 1'b0, '0},
      '{16'd65534, 1'b0, 1'b0, '0},
      '{16'd7,     1'b0, 1'b0, '0},
      '{16'd500,   1'b1, 1'b0, '0},
      '{16'd21845, 1'b0, 1'b0, '0},
      '{16'd43690, 1'b0, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      r = longint'($floor($sqrt(real'(v))));
      // Double precision can be a step out for large sums, so settle it exactly.
      while (r * r > v) r--;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic logic signed [NormBits-1:0] to_q15(longint unsigned mag, bit neg,
                                                        longint unsigned root);
      longint unsigned       q;
      logic [NormBits-1:0]   m;
      q = (mag * 32768 + root / 2) / root;
      if (q > Q15Max) q = Q15Max;
      m = q[NormBits-1:0];
      return neg ? -m : m;
   endfunction

   function automatic bit predict_vertex_normal(input logic [SampleBits-1:0] height,
                                                input logic frame_start,
                                                output vertex_normal_t nrm);
      int unsigned           w, c, r, sh;
      longint                lv, rv, uv, hv, scale, sa, sc;
      longint unsigned       ma, mb, mc, top, a, b, cz, root;
      logic [SampleBits-1:0] up;
      bit                    hit;
      w = width_reg;
      if (w < MinRowWidth) w = MinRowWidth;
      if (w > MaxRowWidth) w = MaxRowWidth;
      if (frame_start) begin
         pred_col = 0;
         pred_row = 0;
      end
      c = pred_col;
      r = pred_row;
      if (c >= MaxRowWidth) c = MaxRowWidth - 1;
      up = older_row[c];
      older_row[c] = newer_row[c];
      newer_row[c] = height;
      hit = r >= 2 && r <= w - 1 && c >= 1 && c <= w - 2;
      nrm = '0;
      if (hit) begin
         // Left has already moved into the older store this row; right has not.
         lv = older_row[c - 1];
         rv = newer_row[c + 1];
         uv = up;
         hv = height;
         scale = scale_reg;
         sa = (rv - lv) * scale;
         sc = (hv - uv) * scale;
         ma = sa < 0 ? -sa : sa;
         mc = sc < 0 ? -sc : sc;
         mb = YTerm;
         top = mb;
         if (ma > top) top = ma;
         if (mc > top) top = mc;
         sh = 0;
         while ((top >> sh) >= (64'd1 << MagBits)) sh++;
         a = ma >> sh;
         b = mb >> sh;
         cz = mc >> sh;
         root = floor_root(a * a + b * b + cz * cz);
         if (root == 0) root = 1;
         nrm.grid_x = CoordBits'(c - 1);
         nrm.grid_z = CoordBits'(r - 2);
         nrm.normal_x = to_q15(a, sa < 0, root);
         nrm.normal_y = to_q15(b, 1'b0, root);
         nrm.normal_z = to_q15(cz, sc < 0, root);
         nrm.last_normal = r == w - 1 && c == w - 2;
      end
      if (c + 1 >= w) begin
         pred_col = 0;
         pred_row = (r + 1 >= w) ? 0 : r + 1;
      end else begin
         pred_col = c + 1;
      end
      return hit;
   endfunction

   function automatic logic [SampleBits-1:0] pick_height(height_mode_t mode);
      int v;
      case (mode)
         HEIGHT_SMOOTH: begin
            v = int'(last_height) + int'($urandom_range(0, 2000)) - 1000;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
         end
         HEIGHT_EXTREME: begin
            case ($urandom_range(0, 3))
               0: v = 0;
               1: v = 65535;
               2: v = 32767;
               default: v = 32768;
            endcase
         end
         HEIGHT_LOW: v = $urandom_range(0, 15);
         default: v = $urandom_range(0, 65535);
      endcase
      last_height = SampleBits'(v);
      return SampleBits'(v);
   endfunction

   task automatic write_register(csr_index_type idx, int unsigned value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CsrDataBits'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ROW_WIDTH) width_reg = value % (1 << RowWidthBits);
      else scale_reg = value % (1 << ScaleBits);
   endtask

   // Waits for every outstanding normal, then for the block to finish any border sample.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (normals_due.size() != 0);
      repeat (SettleCycles) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic offer_height(input logic [SampleBits-1:0] height, input logic frame_start,
                               input bit typed, input vertex_normal_t typed_want);
      int unsigned    gap;
      bit             hit;
      vertex_normal_t nrm;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 90) : $urandom_range(1, 4);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid         <= 1'b1;
      req_if.height_sample <= height;
      req_if.frame_start   <= frame_start;
      do @(posedge clock); while (!req_if.ready);
      hit = predict_vertex_normal(height, frame_start, nrm);
      if (typed) normals_due.push_back(typed_want);
      else if (hit) normals_due.push_back(nrm);
   endtask

   task automatic stream_heights(int unsigned count, bit open_frame, bit noisy,
                                 height_mode_t mode);
      for (int unsigned i = 0; i < count; i++) begin
         offer_height(pick_height(mode),
                      (i == 0 && open_frame) || (noisy && $urandom_range(0, 63) == 0),
                      1'b0, '0);
      end
   endtask

   initial begin
      height_mode_t mode;
      int unsigned  fed, w_eff, count;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_ROW_WIDTH;
      csr_wr_data          <= '0;
      req_if.valid         <= 1'b0;
      req_if.height_sample <= '0;
      req_if.frame_start   <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_register(CSR_ROW_WIDTH, 4);
      write_register(CSR_HEIGHT_SCALE, 65535);
      foreach (demo_rows[i]) begin
         offer_height(demo_rows[i].height, demo_rows[i].frame_start, demo_rows[i].known,
                      demo_rows[i].want);
      end

      // Two full rows at the widest setting leave every entry of both stores written.
      settle();
      write_register(CSR_ROW_WIDTH, MaxRowWidth);
      write_register(CSR_HEIGHT_SCALE, 1);
      stream_heights(2 * MaxRowWidth + 100, 1'b1, 1'b0, HEIGHT_NOISE);
      settle();
      write_register(CSR_ROW_WIDTH, 511);
      write_register(CSR_HEIGHT_SCALE, 65535);
      stream_heights(MaxRowWidth - 100 + 20, 1'b0, 1'b0, HEIGHT_SMOOTH);
      // Shrink under the minimum with the column counter past the new last column, on the last row.
      settle();
      write_register(CSR_ROW_WIDTH, 2);
      stream_heights(20, 1'b0, 1'b0, HEIGHT_EXTREME);

      fed = 0;
      while (fed < RandomItems) begin
         settle();
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: write_register(CSR_ROW_WIDTH, $urandom_range(0, 3));
               1: write_register(CSR_ROW_WIDTH, $urandom_range(13, 24));
               default: write_register(CSR_ROW_WIDTH, $urandom_range(4, 12));
            endcase
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0: write_register(CSR_HEIGHT_SCALE, 0);
               1: write_register(CSR_HEIGHT_SCALE, 1);
               2: write_register(CSR_HEIGHT_SCALE, 65535);
               3: write_register(CSR_HEIGHT_SCALE, $urandom_range(1, 512));
               default: write_register(CSR_HEIGHT_SCALE, $urandom_range(0, 65535));
            endcase
         end
         w_eff = width_reg < MinRowWidth ? MinRowWidth : width_reg;
         count = $urandom_range(1, 2) * w_eff * w_eff;
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w_eff * w_eff - 1);
         mode = height_mode_t'($urandom_range(0, 3));
         gaps_on = $urandom_range(0, 3) != 0;
         // Some phases carry on from mid-frame so that widths mix within a frame.
         stream_heights(count, $urandom_range(0, 3) != 0, 1'b1, mode);
         fed += count;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("** heightmap_normal_central_difference: PASSED **");
      end else begin
         $display("** heightmap_normal_central_difference: FAILED **");
      end
      $finish;
   end

   // The receiver cycles through its own stall pattern and once holds off for a long stretch.
   initial begin
      int unsigned tick, taken, hold_left;
      bit          held;
      tick = 0;
      taken = 0;
      hold_left = 0;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) taken++;
         tick++;
         if (!held && taken >= HoldAfter) begin
            held = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case ((tick / 64) % 4)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= $urandom_range(0, 1);
               2: rsp_if.ready <= (tick % 4) == 0;
               default: rsp_if.ready <= $urandom_range(0, 4) != 0;
            endcase
         end
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      vertex_normal_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (normals_due.size() == 0) begin
            $display("%0t: normal for vertex (%0d, %0d) arrived with none expected", $time,
                     rsp_if.grid_x, rsp_if.grid_z);
            mismatch_count++;
         end else begin
            want = normals_due.pop_front();
            check_field("grid_x", want.grid_x, rsp_if.grid_x);
            check_field("grid_z", want.grid_z, rsp_if.grid_z);
            check_field("normal_x", want.normal_x, rsp_if.normal_x);
            check_field("normal_y", want.normal_y, rsp_if.normal_y);
            check_field("normal_z", want.normal_z, rsp_if.normal_z);
            check_field("last_normal", want.last_normal, rsp_if.last_normal);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("** heightmap_normal_central_difference: FAILED **");
      $finish;
   end

endmodule
